FILE: src/lrst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrst_pkg;

    // Field widths of the channels
    localparam int SYM_W   = 16;
    localparam int COUNT_W = 16;
    localparam int OCC_W   = 6;
    localparam int CAP_W   = 6;

    // Widths that cover the whole parameter range (256 entries, 32-bit ids)
    localparam int MAX_IDX_W = 8;
    localparam int MAX_ID_W  = 32;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_ENTRIES = 32;
    localparam int DEF_ID_BITS     = 16;

    localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(16);
    localparam logic [COUNT_W-1:0] EVICT_LIMIT = COUNT_W'(10000);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

    typedef enum logic [1:0] {
        ST_HIT          = 2'd0,
        ST_INSERT       = 2'd1,
        ST_EVICT_INSERT = 2'd2,
        ST_DROP         = 2'd3
    } status_t;

    typedef struct packed {
        logic [SYM_W-1:0]   symbol_id;
        logic [COUNT_W-1:0] initial_count;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] count_after;
        logic [SYM_W-1:0]   evicted_id;
        logic [OCC_W-1:0]   occupancy;
    } rsp_t;

    // Scan wavefront handed from cell to cell
    typedef struct packed {
        logic                 hit;
        logic [MAX_IDX_W-1:0] hit_idx;
        logic [COUNT_W-1:0]   hit_cnt;
        logic                 have;
        logic [COUNT_W-1:0]   min_cnt;
        logic [MAX_IDX_W-1:0] vic_idx;
        logic [MAX_ID_W-1:0]  vic_id;
    } wave_t;

    // Table update broadcast to all cells
    typedef struct packed {
        logic                 inc;
        logic [MAX_IDX_W-1:0] hit_idx;
        logic                 shift;
        logic [MAX_IDX_W-1:0] vic_idx;
        logic                 load;
        logic [MAX_IDX_W-1:0] app_idx;
        logic [MAX_ID_W-1:0]  new_id;
        logic [COUNT_W-1:0]   new_cnt;
    } cmd_t;

endpackage

`default_nettype wire

FILE: src/lrst_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lrst_cell #(
    parameter int MAX_ENTRIES = lrst_pkg::DEF_MAX_ENTRIES,
    parameter int ID_BITS     = lrst_pkg::DEF_ID_BITS,
    parameter int IDX         = 0
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic [$clog2(MAX_ENTRIES+1)-1:0]      total,
    input  wire logic [ID_BITS-1:0]                    query_id,
    input  wire logic                                  wave_vld_in,
    input  wire lrst_pkg::wave_t                       wave_in,
    output logic                                       wave_vld_out,
    output lrst_pkg::wave_t                            wave_out,
    input  wire lrst_pkg::cmd_t                        cmd,
    input  wire logic [ID_BITS-1:0]                    right_id,
    input  wire logic [lrst_pkg::COUNT_W-1:0]          right_cnt,
    output logic [ID_BITS-1:0]                         id_out,
    output logic [lrst_pkg::COUNT_W-1:0]               cnt_out
);
    import lrst_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [MAX_IDX_W-1:0] MY_IDX = MAX_IDX_W'(IDX);

    logic [ID_BITS-1:0] id_reg, id_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               wave_vld_reg;
    wave_t              wave_reg, wave_next;
    logic               occupied;
    logic               match;
    logic               lower;

    // Fold this entry into the passing wavefront
    always_comb
    begin
        occupied  = CNT_W'(IDX) < total;
        match     = occupied && (id_reg == query_id);
        lower     = occupied && (cnt_reg < wave_in.min_cnt);
        wave_next = wave_in;
        if (match && !wave_in.hit)
        begin
            wave_next.hit     = 1'b1;
            wave_next.hit_idx = MY_IDX;
            wave_next.hit_cnt = cnt_reg;
        end
        // strict compare keeps the earliest of equal minimums
        if (lower)
        begin
            wave_next.have    = 1'b1;
            wave_next.min_cnt = cnt_reg;
            wave_next.vic_idx = MY_IDX;
            wave_next.vic_id  = MAX_ID_W'(id_reg);
        end
    end

    // Entry update: append wins over compaction, bump on a hit
    always_comb
    begin
        id_next  = id_reg;
        cnt_next = cnt_reg;
        if (cmd.load && (cmd.app_idx == MY_IDX))
        begin
            id_next  = cmd.new_id[ID_BITS-1:0];
            cnt_next = cmd.new_cnt;
        end
        else if (cmd.inc && (cmd.hit_idx == MY_IDX))
        begin
            if (cnt_reg != COUNT_MAX)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        else if (cmd.shift && (MY_IDX >= cmd.vic_idx))
        begin
            id_next  = right_id;
            cnt_next = right_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_vld_reg <= 1'b0;
        end
        else
        begin
            wave_vld_reg <= wave_vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        cnt_reg  <= cnt_next;
        wave_reg <= wave_next;
    end

    assign wave_vld_out = wave_vld_reg;
    assign wave_out     = wave_reg;
    assign id_out       = id_reg;
    assign cnt_out      = cnt_reg;

endmodule

`default_nettype wire

FILE: src/lfu_recent_symbol_table.sv
// Least-frequently-used table of recently used symbols.
// req channel: one word per use event (symbol id, starting use count).
// rsp channel: one word per request (status, count after, evicted id,
//   occupancy). cfg channel: writes the 6-bit capacity; write only when idle.
// A hit bumps the entry's count (saturating). A miss at or above capacity
// evicts the first entry with the lowest count below 10000, compacts the
// rest, then appends; with the table physically full and no eviction (nothing
// evictable, or the capacity above the physical size) the request is dropped.
// Each request steps through launch, a scan whose wavefront moves one cell
//   per cycle down the chain, and decide, which registers the response and
//   the table update; a new request is accepted only once the last one has
//   been decided.
// Reset: table empty, capacity 16, no response pending.
// Stall: a finished response sits in the output register; the next request
//   is still accepted and scanned, and its table update and response wait
//   until the receiver takes the pending word.
`timescale 1ns / 1ps
`default_nettype none

module lfu_recent_symbol_table #(
    parameter int MAX_ENTRIES = lrst_pkg::DEF_MAX_ENTRIES,
    parameter int ID_BITS     = lrst_pkg::DEF_ID_BITS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_ready,
    input  wire lrst_pkg::req_t            req_data,
    output logic                           rsp_valid,
    input  wire logic                      rsp_ready,
    output lrst_pkg::rsp_t                 rsp_data,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [lrst_pkg::CAP_W-1:0] cfg_data
);
    import lrst_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_SCAN,
        S_DECIDE
    } state_t;

    state_t             state_reg, state_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [ID_BITS-1:0] q_id_reg, q_id_next;
    logic [COUNT_W-1:0] q_init_reg, q_init_next;
    wave_t              hold_reg, hold_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;
    cmd_t               cmd_reg, cmd_next;

    wave_t              wave_chain [MAX_ENTRIES+1];
    logic               wave_vld_chain [MAX_ENTRIES+1];
    logic [ID_BITS-1:0] cell_id [MAX_ENTRIES+1];
    logic [COUNT_W-1:0] cell_cnt [MAX_ENTRIES+1];

    logic [MAX_ID_W-1:0] sym_ext;
    logic               slot_free;
    logic               try_evict;
    logic               do_evict;
    logic [CNT_W-1:0]   total_trim;
    logic               room;
    logic [COUNT_W-1:0] hit_count;

    // Wavefront entering the head cell
    always_comb
    begin
        wave_chain[0]         = '0;
        wave_chain[0].min_cnt = EVICT_LIMIT;
        wave_vld_chain[0]     = (state_reg == S_LAUNCH);
    end

    // Past the last cell the table reads as empty
    assign cell_id[MAX_ENTRIES]  = '0;
    assign cell_cnt[MAX_ENTRIES] = '0;

    // Chain of entry cells
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        lrst_cell #(
            .MAX_ENTRIES (MAX_ENTRIES),
            .ID_BITS     (ID_BITS),
            .IDX         (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .total        (total_reg),
            .query_id     (q_id_reg),
            .wave_vld_in  (wave_vld_chain[i]),
            .wave_in      (wave_chain[i]),
            .wave_vld_out (wave_vld_chain[i+1]),
            .wave_out     (wave_chain[i+1]),
            .cmd          (cmd_reg),
            .right_id     (cell_id[i+1]),
            .right_cnt    (cell_cnt[i+1]),
            .id_out       (cell_id[i]),
            .cnt_out      (cell_cnt[i])
        );
    end

    // Outcome of a finished scan
    always_comb
    begin
        sym_ext    = MAX_ID_W'(req_data.symbol_id);
        slot_free  = !rsp_valid_reg || rsp_ready;
        try_evict  = CMP_W'(total_reg) >= CMP_W'(cap_reg);
        do_evict   = !hold_reg.hit && try_evict && hold_reg.have;
        total_trim = total_reg - CNT_W'(do_evict);
        room       = total_trim < CNT_W'(MAX_ENTRIES);
        hit_count  = (hold_reg.hit_cnt == COUNT_MAX) ? hold_reg.hit_cnt
                                                     : hold_reg.hit_cnt + 1'b1;
    end

    // Sequencer: accept, launch, scan, decide
    always_comb
    begin
        state_next     = state_reg;
        cap_next       = cap_reg;
        total_next     = total_reg;
        q_id_next      = q_id_reg;
        q_init_next    = q_init_reg;
        hold_next      = hold_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        cmd_next       = '0;

        if (cfg_valid)
        begin
            cap_next = cfg_data;
        end
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    q_id_next   = sym_ext[ID_BITS-1:0];
                    q_init_next = req_data.initial_count;
                    state_next  = S_LAUNCH;
                end
            end
            S_LAUNCH:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (wave_vld_chain[MAX_ENTRIES])
                begin
                    hold_next  = wave_chain[MAX_ENTRIES];
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    if (hold_reg.hit)
                    begin
                        rsp_next.status      = ST_HIT;
                        rsp_next.count_after = hit_count;
                        cmd_next.inc         = 1'b1;
                        cmd_next.hit_idx     = hold_reg.hit_idx;
                    end
                    else if (room)
                    begin
                        rsp_next.status      = do_evict ? ST_EVICT_INSERT : ST_INSERT;
                        rsp_next.count_after = q_init_reg;
                        rsp_next.evicted_id  = do_evict ? hold_reg.vic_id[SYM_W-1:0]
                                                        : '0;
                        total_next           = total_trim + 1'b1;
                        cmd_next.shift       = do_evict;
                        cmd_next.vic_idx     = hold_reg.vic_idx;
                        cmd_next.load        = 1'b1;
                        cmd_next.app_idx     = MAX_IDX_W'(total_trim);
                        cmd_next.new_id      = MAX_ID_W'(q_id_reg);
                        cmd_next.new_cnt     = q_init_reg;
                    end
                    else
                    begin
                        rsp_next.status = ST_DROP;
                    end
                    rsp_next.occupancy = OCC_W'(total_next);
                    state_next         = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET;
            total_reg     <= '0;
            q_id_reg      <= '0;
            q_init_reg    <= '0;
            hold_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            cmd_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            total_reg     <= total_next;
            q_id_reg      <= q_id_next;
            q_init_reg    <= q_init_next;
            hold_reg      <= hold_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
            cmd_reg       <= cmd_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign cfg_ready = 1'b1;

    // Entry count never passes the physical size
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    // Wavefront leaves the chain only while a scan is running
    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wave_vld_chain[MAX_ENTRIES] |-> (state_reg == S_SCAN))
        else $error("scan result outside scan state");

    // Table updates come only from a decision
    a_cmd_source: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_reg.inc || cmd_reg.load || cmd_reg.shift) |-> $past(state_reg == S_DECIDE))
        else $error("table update without decision");

    // A dropped insert means the table is full
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status == ST_DROP)) |-> (total_reg == CNT_W'(MAX_ENTRIES)))
        else $error("insert dropped with room left");

endmodule

`default_nettype wire

FILE: tb/lrst_checker.sv
`timescale 1ns / 1ps

// Watches the req, rsp and cfg channels of the symbol table, keeps its own
// copy of the table and capacity, and checks every rsp word in order.
module lrst_checker #(
    parameter int SLOTS = lrst_pkg::DEF_MAX_ENTRIES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  lrst_pkg::req_t                req_data,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  lrst_pkg::rsp_t                rsp_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [lrst_pkg::CAP_W-1:0]    cfg_data,
    output int                            fail_count,
    output int                            words_pending,
    output logic [3:0][31:0]              status_tally
);
    import lrst_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Shadow table, kept in insertion order
    logic [SYM_W-1:0]   sym_ids    [SLOTS];
    logic [COUNT_W-1:0] use_counts [SLOTS];
    int                 live;
    logic [CAP_W-1:0]   cap_reg;
    rsp_t               expected_words [$];
    int                 words_seen;

    // Applies one use event to the shadow table and returns the rsp word it causes
    function automatic rsp_t apply_use(input req_t w);
        rsp_t             r;
        int               hit_at;
        int               victim;
        logic [COUNT_W-1:0] lowest;
        r.status      = ST_INSERT;
        r.count_after = '0;
        r.evicted_id  = '0;
        hit_at        = -1;
        victim        = -1;
        for (int i = 0; i < live; i++)
        begin
            if (hit_at < 0 && sym_ids[i] == w.symbol_id)
                hit_at = i;
        end
        if (hit_at >= 0)
        begin
            // hit: bump the count, saturating at the top
            if (use_counts[hit_at] != COUNT_MAX)
                use_counts[hit_at] = use_counts[hit_at] + 1'b1;
            r.status      = ST_HIT;
            r.count_after = use_counts[hit_at];
        end
        else
        begin
            // miss at or above capacity: first entry with the lowest count below the limit goes
            if (live >= cap_reg)
            begin
                lowest = EVICT_LIMIT;
                for (int i = 0; i < live; i++)
                begin
                    if (use_counts[i] < lowest)
                    begin
                        lowest = use_counts[i];
                        victim = i;
                    end
                end
            end
            if (victim >= 0)
            begin
                r.evicted_id = sym_ids[victim];
                for (int i = victim; i + 1 < live; i++)
                begin
                    sym_ids[i]    = sym_ids[i + 1];
                    use_counts[i] = use_counts[i + 1];
                end
                live--;
            end
            // append, or drop when physically full
            if (live < SLOTS)
            begin
                sym_ids[live]    = w.symbol_id;
                use_counts[live] = w.initial_count;
                live++;
                r.count_after = w.initial_count;
                if (victim >= 0)
                    r.status = ST_EVICT_INSERT;
                else
                    r.status = ST_INSERT;
            end
            else
            begin
                r.status = ST_DROP;
            end
        end
        r.occupancy = OCC_W'(live);
        return r;
    endfunction

    // Predict on req accept, compare on rsp accept
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            live         = 0;
            cap_reg      = CAP_RESET;
            fail_count   = 0;
            words_seen   = 0;
            status_tally = '0;
            expected_words.delete();
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                words_seen++;
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("rsp word %0d arrived with nothing expected: %0d %0d %0h %0d",
                                 words_seen, rsp_data.status, rsp_data.count_after,
                                 rsp_data.evicted_id, rsp_data.occupancy);
                end
                else
                begin
                    want = expected_words.pop_front();
                    status_tally[want.status] = status_tally[want.status] + 1;
                    if (rsp_data.status !== want.status
                        || rsp_data.count_after !== want.count_after
                        || rsp_data.evicted_id !== want.evicted_id
                        || rsp_data.occupancy !== want.occupancy)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("rsp word %0d mismatch: expected st %0d cnt %0d ev %0h occ %0d, got st %0d cnt %0d ev %0h occ %0d",
                                     words_seen, want.status, want.count_after,
                                     want.evicted_id, want.occupancy, rsp_data.status,
                                     rsp_data.count_after, rsp_data.evicted_id,
                                     rsp_data.occupancy);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                cap_reg = cfg_data;
            if (req_valid && req_ready)
                expected_words.push_back(apply_use(req_data));
        end
        words_pending = expected_words.size();
    end

endmodule

FILE: tb/tb_lfu_recent_symbol_table.sv
`timescale 1ns / 1ps

// Drives use events into the symbol table under random flow control and
// sweeps the capacity register; lrst_checker does the predicting and checking.
module tb_lfu_recent_symbol_table;
    import lrst_pkg::*;

    localparam int SLOTS           = DEF_MAX_ENTRIES;
    localparam int IDLE_PCT        = 36;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = SLOTS + 8;
    localparam int WATCHDOG_LIMIT  = 4000;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    req_t               req_data;
    logic               rsp_valid;
    logic               rsp_ready;
    rsp_t               rsp_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CAP_W-1:0]   cfg_data;

    int                 fail_count;
    int                 words_pending;
    logic [3:0][31:0]   status_tally;
    int                 tx_idle_pct;
    int                 rx_idle_pct;
    bit                 hold_request;
    int                 idle_cycles;

    lfu_recent_symbol_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lrst_checker #(.SLOTS(SLOTS)) chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_data      (req_data),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp_data      (rsp_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .words_pending (words_pending),
        .status_tally  (status_tally)
    );

    // 125 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Starting counts: half low and tied, the rest mostly spread below the eviction limit,
    // a few near it, high ones only as often as asked (those entries can never be evicted)
    function automatic logic [COUNT_W-1:0] pick_start_count(input int high_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < high_pct)
        begin
            if ($urandom_range(0, 3) == 0)
                return COUNT_MAX - COUNT_W'($urandom_range(0, 2));
            return COUNT_W'($urandom_range(10000, 65535));
        end
        roll = $urandom_range(0, 19);
        if (roll < 10)
            return COUNT_W'($urandom_range(0, 7));
        if (roll < 19)
            return COUNT_W'($urandom_range(0, 9999));
        return COUNT_W'($urandom_range(9990, 9999));
    endfunction

    function automatic req_t make_word(input logic [SYM_W-1:0] id,
                                       input logic [COUNT_W-1:0] cnt);
        req_t w;
        w.symbol_id     = id;
        w.initial_count = cnt;
        return w;
    endfunction

    // Random gap, then hold the word until accepted; returns just after the accepting edge
    task automatic send_word(input req_t w);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= w;
        do @(negedge clk); while (!req_ready);
        @(posedge clk);
    endtask

    // Wait until every rsp word has come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(negedge clk); while (words_pending != 0);
        @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Extremes of both fields, hits, saturation and crossing the eviction limit
    task automatic run_directed();
        send_word(make_word(16'h0000, 16'h0000));
        send_word(make_word(16'hFFFF, 16'hFFFF));
        send_word(make_word(16'hFFFF, 16'h0000));
        send_word(make_word(16'h0000, 16'hFFFF));
        send_word(make_word(16'h0001, 16'd9999));
        send_word(make_word(16'h0001, 16'h0000));
        send_word(make_word(16'h0002, 16'd10000));
        send_word(make_word(16'h5555, 16'hAAAA));
        send_word(make_word(16'hAAAA, 16'h5555));
        send_word(make_word(16'h0003, 16'hFFFE));
        send_word(make_word(16'h0003, 16'h1234));
        send_word(make_word(16'h0003, 16'h0000));
    endtask

    // One capacity setting, ids mostly from a small pool so hits and evictions happen
    task automatic run_phase(input logic [CAP_W-1:0] cap_value, input int n_words,
                             input int pool_size, input int high_pct, input bit hold_mid);
        logic [SYM_W-1:0] pool [$];
        req_t             w;
        bit               fresh;
        write_capacity(cap_value);
        repeat (pool_size) pool.push_back(SYM_W'($urandom));
        for (int n = 0; n < n_words; n++)
        begin
            if (hold_mid && n == 10)
                hold_request = 1'b1;
            fresh = ($urandom_range(0, 99) < 12);
            if (fresh)
            begin
                w.symbol_id     = SYM_W'($urandom);
                w.initial_count = pick_start_count(0);
            end
            else
            begin
                w.symbol_id     = pool[$urandom_range(0, pool_size - 1)];
                w.initial_count = pick_start_count(high_pct);
            end
            send_word(w);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog on cycles with no handshake on any channel
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_data     = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        hold_request = 1'b0;
        tx_idle_pct  = IDLE_PCT;
        rx_idle_pct  = IDLE_PCT;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_phase(CAP_W'(0), 120, 5, 15, 1'b0);
        run_phase(CAP_W'(1), 120, 4, 5, 1'b0);
        // no idling on either side for this stretch
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(CAP_W'(5), 150, 6, 0, 1'b0);
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
        // capacity above physical size: full table drops even with evictable entries
        run_phase(CAP_W'(63), 150, 80, 0, 1'b0);
        run_phase(CAP_W'(33), 80, 80, 0, 1'b0);
        run_phase(CAP_W'(16), 150, 20, 0, 1'b1);
        repeat (2)
            run_phase(CAP_W'($urandom_range(2, 31)), 110, $urandom_range(4, 24),
                      $urandom_range(0, 3), 1'b0);
        // fill with unevictable entries, then misses drop
        run_phase(CAP_W'(32), 150, 60, 90, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d hits, %0d inserts, %0d evict+inserts, %0d drops",
                 status_tally[ST_HIT], status_tally[ST_INSERT],
                 status_tally[ST_EVICT_INSERT], status_tally[ST_DROP]);
        $display("capacity swept over 0, 1, 5, 16, 32, 33, 63 and two random values; %0d-cycle rsp hold-off",
                 HOLD_OFF_CYCLES);
        if (fail_count == 0 && words_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: lfu_recent_symbol_table.f
src/lrst_pkg.sv
src/lrst_cell.sv
src/lfu_recent_symbol_table.sv
tb/lrst_checker.sv
tb/tb_lfu_recent_symbol_table.sv
